>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/rtds_pkg.sv
// ----------------------------------------------------------------------------
// rtds_pkg
// Widths, register indexes, constants and types of the range to duty scaler.
// ----------------------------------------------------------------------------
package rtds_pkg;

  localparam int VALUE_W  = 32;
  localparam int DUTY_W   = 16;
  localparam int QUOT_W   = 16;
  localparam int PROD_W   = VALUE_W + QUOT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 2'd2;

  localparam logic [DUTY_W-1:0]  FULL_SCALE  = 16'hFFFF;
  localparam logic [DUTY_W-1:0]  LOOP_FLOOR  = 16'd13107;
  localparam logic [DUTY_W-1:0]  LOOP_SCALE  = FULL_SCALE - LOOP_FLOOR;
  localparam logic [VALUE_W-1:0] UPPER_RESET = 32'd65535;
  localparam logic [VALUE_W-1:0] LOWER_RESET = 32'd0;

  // Ordered range and output mapping, derived from the config registers.
  typedef struct packed {
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] span;
    logic [DUTY_W-1:0]  scale;
    logic [DUTY_W-1:0]  floor_val;
    logic               zero;
  } cfg_t;

endpackage

>>> src/rtds_cfg.sv
// ----------------------------------------------------------------------------
// rtds_cfg
// Config registers and the registered, ordered range derived from them.
// ----------------------------------------------------------------------------
module rtds_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rtds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rtds_pkg::VALUE_W-1:0]       cfg_wdata_i,
  output rtds_pkg::cfg_t                     cfg_o
);

  logic [rtds_pkg::VALUE_W-1:0] upper_d;
  logic [rtds_pkg::VALUE_W-1:0] upper_q;
  logic [rtds_pkg::VALUE_W-1:0] lower_d;
  logic [rtds_pkg::VALUE_W-1:0] lower_q;
  logic                         mode_d;
  logic                         mode_q;
  rtds_pkg::cfg_t               cfg_d;
  rtds_pkg::cfg_t               cfg_q;
  logic                         swap;

  always_comb begin
    upper_d = upper_q;
    lower_d = lower_q;
    mode_d  = mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rtds_pkg::REG_RANGE_UPPER: upper_d = cfg_wdata_i;
        rtds_pkg::REG_RANGE_LOWER: lower_d = cfg_wdata_i;
        rtds_pkg::REG_LOOP_MODE:   mode_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= rtds_pkg::UPPER_RESET;
      lower_q <= rtds_pkg::LOWER_RESET;
      mode_q  <= 1'b0;
    end else begin
      upper_q <= upper_d;
      lower_q <= lower_d;
      mode_q  <= mode_d;
    end
  end

  // Derived from the next register values, so a write takes effect at its edge.
  always_comb begin
    swap            = lower_d > upper_d;
    cfg_d.lo        = swap ? upper_d : lower_d;
    cfg_d.hi        = swap ? lower_d : upper_d;
    cfg_d.span      = cfg_d.hi - cfg_d.lo;
    cfg_d.zero      = upper_d == lower_d;
    cfg_d.scale     = mode_d ? rtds_pkg::LOOP_SCALE : rtds_pkg::FULL_SCALE;
    cfg_d.floor_val = mode_d ? rtds_pkg::LOOP_FLOOR : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo        <= rtds_pkg::LOWER_RESET;
      cfg_q.hi        <= rtds_pkg::UPPER_RESET;
      cfg_q.span      <= rtds_pkg::UPPER_RESET - rtds_pkg::LOWER_RESET;
      cfg_q.zero      <= 1'b0;
      cfg_q.scale     <= rtds_pkg::FULL_SCALE;
      cfg_q.floor_val <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/rtds_map.sv
// ----------------------------------------------------------------------------
// rtds_map
// Clamp to the ordered range and offset (stage 1), then scale (stage 2).
// ----------------------------------------------------------------------------
module rtds_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtds_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rtds_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rtds_pkg::PROD_W-1:0]   prod_o
);

  logic                         v1_q;
  logic                         v2_q;
  logic                         rdy1;
  logic                         rdy2;
  logic [rtds_pkg::VALUE_W-1:0] off_d;
  logic [rtds_pkg::VALUE_W-1:0] off_q;
  logic [rtds_pkg::PROD_W-1:0]  prod_d;
  logic [rtds_pkg::PROD_W-1:0]  prod_q;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Clamp folded into the offset: below range gives 0, above gives the span.
  always_comb begin
    if (value_i < cfg_i.lo) begin
      off_d = '0;
    end else if (value_i > cfg_i.hi) begin
      off_d = cfg_i.span;
    end else begin
      off_d = value_i - cfg_i.lo;
    end
  end

  assign prod_d = rtds_pkg::PROD_W'(off_q) * rtds_pkg::PROD_W'(cfg_i.scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      off_q <= off_d;
    end
    if (rdy2 && v1_q) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = v2_q;
  assign prod_o      = prod_q;

endmodule

>>> src/rtds_div.sv
// ----------------------------------------------------------------------------
// rtds_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtds_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rtds_pkg::VALUE_W-1:0]  span_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rtds_pkg::PROD_W-1:0]   prod_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rtds_pkg::QUOT_W-1:0]   quot_o
);

  localparam int N = rtds_pkg::QUOT_W;

  // Quotient < 2^QUOT_W since the offset never exceeds the span, so the
  // upper product bits start below the divisor.
  logic [N-1:0]                  v_q;
  logic [N-1:0]                  rdy;
  logic [rtds_pkg::VALUE_W-1:0]  rem_q [N];
  logic [N-1:0]                  lq_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                          v_in;
    logic [rtds_pkg::VALUE_W-1:0]  rem_in;
    logic [N-1:0]                  lq_in;
    logic                          rdy_next;
    logic [rtds_pkg::VALUE_W:0]    t;
    logic [rtds_pkg::VALUE_W:0]    diff;
    logic                          ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = prod_i[rtds_pkg::PROD_W-1:N];
      assign lq_in  = prod_i[N-1:0];
    end else begin : g_rest
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign lq_in  = lq_q[k-1];
    end

    if (k == N-1) begin : g_last
      assign rdy_next = out_ready_i;
    end else begin : g_mid
      assign rdy_next = rdy[k+1];
    end

    assign rdy[k] = !v_q[k] || rdy_next;
    assign t      = {rem_in, lq_in[N-1]};
    assign diff   = t - {1'b0, span_i};
    assign ge     = t >= {1'b0, span_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k] <= ge ? diff[rtds_pkg::VALUE_W-1:0] : t[rtds_pkg::VALUE_W-1:0];
        lq_q[k]  <= {lq_in[N-2:0], ge};
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign quot_o      = lq_q[N-1];

endmodule

>>> src/range_to_duty_scaler.sv
// ----------------------------------------------------------------------------
// range_to_duty_scaler
// Maps a 32-bit engineering value onto a 16-bit PWM duty word.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  in        in_valid_i, in_ready_o, input_value_i      sink
//  out       out_valid_o, out_ready_i, duty_word_o      source
//  cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i           write only
//
// One item per cycle unless out_ready_i holds it back; the stages are offset,
// multiply, 16 divider stages (one quotient bit each) and output register.
// Reset: range 0..65535, current-loop mode off. The ordered range is
// registered at the write edge, so items accepted after it see the new value.
// Stalls: a full stage holds while the stage after it is full and held; bubbles close up.
// ----------------------------------------------------------------------------
module range_to_duty_scaler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rtds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rtds_pkg::VALUE_W-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rtds_pkg::VALUE_W-1:0]       input_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rtds_pkg::DUTY_W-1:0]        duty_word_o
);

  rtds_pkg::cfg_t               cfg;
  logic                         map_valid;
  logic                         map_ready;
  logic [rtds_pkg::PROD_W-1:0]  prod;
  logic                         div_valid;
  logic                         div_ready;
  logic [rtds_pkg::QUOT_W-1:0]  quot;
  logic                         out_valid_q;
  logic [rtds_pkg::DUTY_W-1:0]  duty_d;
  logic [rtds_pkg::DUTY_W-1:0]  duty_q;
  logic [rtds_pkg::DUTY_W:0]    sum;

  rtds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rtds_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (input_value_i),
    .out_valid_o (map_valid),
    .out_ready_i (map_ready),
    .prod_o      (prod)
  );

  rtds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .span_i      (cfg.span),
    .in_valid_i  (map_valid),
    .in_ready_o  (map_ready),
    .prod_i      (prod),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quot_o      (quot)
  );

  assign div_ready = !out_valid_q || out_ready_i;

  // Zero span gives the floor; the sum saturates at full scale.
  always_comb begin
    sum = {1'b0, quot} + {1'b0, cfg.floor_val};
    if (cfg.zero) begin
      duty_d = cfg.floor_val;
    end else if (sum[rtds_pkg::DUTY_W]) begin
      duty_d = rtds_pkg::FULL_SCALE;
    end else begin
      duty_d = sum[rtds_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      duty_q <= duty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_word_o = duty_q;

endmodule

>>> src/rtds_checker.sv
// ----------------------------------------------------------------------------
// rtds_checker
// Port-level checks of the range to duty scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtds_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [rtds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input logic [rtds_pkg::VALUE_W-1:0]       cfg_wdata_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [rtds_pkg::DUTY_W-1:0]        duty_word_o
);

  logic loop_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q <= 1'b0;
    end else if (cfg_we_i && cfg_idx_i == rtds_pkg::REG_LOOP_MODE) begin
      loop_mode_q <= cfg_wdata_i[0];
    end
  end

  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_word_o), "stalled duty item changed")
  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "item shown during reset")
  `ASSERT_CLK(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")
  `ASSERT_CLK(a_loop_floor, loop_mode_q && out_valid_o |-> duty_word_o >= rtds_pkg::LOOP_FLOOR, "duty below current-loop floor")

endmodule

bind range_to_duty_scaler rtds_checker u_rtds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .duty_word_o (duty_word_o)
);
